FILE: sv/lem_pkg.sv
// Shared types and constants for the Laplacian edge magnitude filter.
package lem_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int WIDTH_MIN     = 3;
    localparam int HEIGHT_MIN    = 3;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;

    localparam int PIX_W   = 8;
    localparam int FW_W    = 12;
    localparam int FH_W    = 13;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 12;
    localparam int CFG_D_W = 13;
    localparam int CFG_I_W = 1;

    localparam int EDGE_MAX = 255;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [FH_W-1:0]    height_t;
    typedef logic [CFG_I_W-1:0] cfg_idx_t;
    typedef logic [CFG_D_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

endpackage

FILE: sv/laplacian_edge_magnitude_top.sv
// Streaming four-neighbour Laplacian edge magnitude filter, top level.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | sink      | in_valid / in_stall     | pixel
//  out     | source    | out_valid / out_stall   | edge_res, col, row, frame_last
//  cfg     | sink      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One pixel request is taken every clock while in_stall is low; a result is
// loaded into the output register when stage 1 retires its lower-right neighbour,
// and the receiver takes it from there. The rate is set by the single line store
// port pair: one read and one write per clock on one shared {older,newer} word.
// Reset clears counters, window and valid flags; the line stores are not cleared
// and need no clearing pass. in_stall rises only while the output register holds
// a result that is stalled and the stage-1 request also carries a result.
module laplacian_edge_magnitude_top
    import lem_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    // pixel stream
    input  logic      in_valid,
    output logic      in_stall,
    input  pix_t      pixel,
    // results
    output logic      out_valid,
    input  logic      out_stall,
    output pix_t      edge_res,
    output col_t      col,
    output row_t      row,
    output logic      frame_last,
    // register writes
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;   // line store address
    localparam int WW = $clog2(MAX_WIDTH + 1);                      // width value
    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    typedef logic [AW-1:0] addr_t;
    typedef logic [WW-1:0] wval_t;

    // ---------------------------------------------------------------- config
    wval_t   width_reg;
    height_t height_reg;
    wval_t   width_next;
    height_t height_next;
    logic [31:0] fw_ext;
    logic [31:0] fh_ext;

    assign cfg_ready = 1'b1;

    // values are saturated when written, so the datapath sees only legal sizes
    always_comb
    begin
        fw_ext = 32'(cfg_data[FW_W-1:0]);
        fh_ext = 32'(cfg_data[FH_W-1:0]);
        if (fw_ext < 32'(WIDTH_MIN))
            width_next = WW'(WIDTH_MIN);
        else if (fw_ext > 32'(MAX_WIDTH))
            width_next = WW'(MAX_WIDTH);
        else
            width_next = WW'(fw_ext);
        if (fh_ext < 32'(HEIGHT_MIN))
            height_next = FH_W'(HEIGHT_MIN);
        else if (fh_ext > 32'(HEIGHT_LIMIT))
            height_next = FH_W'(HEIGHT_LIMIT);
        else
            height_next = FH_W'(fh_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= FH_W'(HEIGHT_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= width_next;
                REG_FRAME_HEIGHT: height_reg <= height_next;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // ------------------------------------------------------- handshake control
    logic s1_valid_reg;
    logic s1_hasres_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_go;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_hasres_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------- position counters
    // Counters track the incoming pixel and move at acceptance; they do not
    // depend on pixel data, so result flags are worked out here too.
    addr_t col_cnt_reg;
    row_t  row_cnt_reg;
    addr_t col_cnt_next;
    row_t  row_cnt_next;
    wval_t c_ext;
    wval_t c_inc;
    height_t r_ext;
    height_t r_inc;
    logic  has_res;
    logic  is_last;

    always_comb
    begin
        c_ext = WW'(col_cnt_reg);
        c_inc = c_ext + WW'(1);
        r_ext = FH_W'(row_cnt_reg);
        r_inc = r_ext + FH_W'(1);

        has_res = (c_ext >= WW'(2)) && (c_ext < width_reg)
               && (r_ext >= FH_W'(2)) && (r_ext < height_reg);
        is_last = (c_ext == width_reg - WW'(1)) && (r_ext == height_reg - FH_W'(1));

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        priority if (c_inc >= width_reg)
        begin
            col_cnt_next = '0;
            row_cnt_next = (r_inc >= height_reg) ? '0 : r_inc[ROW_W-1:0];
        end
        else if (r_ext >= height_reg)
        begin
            // height shrunk below the current row: restart the frame
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else
        begin
            col_cnt_next = c_inc[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------ line stores
    // One word per column: upper byte is the row two above, lower byte the row
    // just above. Read at acceptance, written back when stage 1 retires.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] s1_line_reg;
    logic [2*PIX_W-1:0] wr_data;
    addr_t              s1_addr_reg;
    pix_t               s1_pix_reg;

    assign wr_data = {s1_line_reg[PIX_W-1:0], s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (s1_go)
            line_mem[s1_addr_reg] <= wr_data;
        if (accept)
        begin
            // same column twice in a row happens on a frame restart
            if (s1_go && (s1_addr_reg == col_cnt_reg))
                s1_line_reg <= wr_data;
            else
                s1_line_reg <= line_mem[col_cnt_reg];
        end
    end

    // ---------------------------------------------------------------- stage 1
    col_t s1_col_reg;
    row_t s1_row_reg;
    logic s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_hasres_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg  <= 1'b1;
            s1_hasres_reg <= has_res;
        end
        else if (s1_go)
        begin
            s1_valid_reg  <= 1'b0;
            s1_hasres_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pixel;
            s1_addr_reg <= col_cnt_reg;
            s1_col_reg  <= COL_W'(c_ext - WW'(1));
            s1_row_reg  <= row_cnt_reg - ROW_W'(1);
            s1_last_reg <= is_last;
        end
    end

    // ---------------------------------------------------- window and kernel
    // left, centre of the middle row; up and down of the centre column.
    // The right neighbour is the row-above byte read for stage 1.
    pix_t win_left_reg;
    pix_t win_centre_reg;
    pix_t win_up_reg;
    pix_t win_down_reg;
    pix_t above1;
    pix_t above2;
    logic [PIX_W+1:0] nb_sum;
    logic signed [PIX_W+2:0] lap;
    logic [PIX_W+2:0] lap_abs;
    pix_t edge_next;

    assign above1 = s1_line_reg[PIX_W-1:0];
    assign above2 = s1_line_reg[2*PIX_W-1:PIX_W];

    always_comb
    begin
        nb_sum = (PIX_W+2)'(win_left_reg) + (PIX_W+2)'(above1)
               + (PIX_W+2)'(win_up_reg) + (PIX_W+2)'(win_down_reg);
        lap = $signed({1'b0, nb_sum}) - $signed({1'b0, win_centre_reg, 2'b00});
        lap_abs = lap[PIX_W+2] ? (PIX_W+3)'(-lap) : (PIX_W+3)'(lap);
        edge_next = (lap_abs > (PIX_W+3)'(EDGE_MAX)) ? PIX_W'(EDGE_MAX) : lap_abs[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_centre_reg <= '0;
            win_up_reg     <= '0;
            win_down_reg   <= '0;
        end
        else if (s1_go)
        begin
            win_left_reg   <= win_centre_reg;
            win_centre_reg <= above1;
            win_up_reg     <= above2;
            win_down_reg   <= s1_pix_reg;
        end
    end

    // ---------------------------------------------------------- output register
    pix_t edge_reg;
    col_t col_reg;
    row_t row_reg;
    logic last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_hasres_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_hasres_reg)
        begin
            edge_reg <= edge_next;
            col_reg  <= s1_col_reg;
            row_reg  <= s1_row_reg;
            last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_res   = edge_reg;
    assign col        = col_reg;
    assign row        = row_reg;
    assign frame_last = last_reg;

endmodule

FILE: sv/lem_checker.sv
// Port-level checks for the Laplacian edge filter, bound to the top level.
module lem_checker
    import lem_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input pix_t edge_res,
    input col_t col,
    input row_t row,
    input logic frame_last
);

    // input backs up only behind a held, stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without stalled result");

    // no result on the top border row
    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (row != '0))
        else $error("result on border row");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped under stall");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(edge_res) && $stable(col)
                                      && $stable(row) && $stable(frame_last)))
        else $error("result changed under stall");

endmodule

bind laplacian_edge_magnitude_top lem_checker u_lem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_res   (edge_res),
    .col        (col),
    .row        (row),
    .frame_last (frame_last)
);
